// File: hw/rtl/sxfd_pkg.sv
// shared types and constants of the sync/length/xor frame decoder
package sxfd_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 1024;

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'h7A;

  localparam int unsigned LEN_W  = 16;
  localparam int unsigned PLEN_W = 11;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHECK = 2'd1,
    ST_BAD_SYNC  = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]        command;
    logic [7:0]        payload_byte;
    logic              is_payload;
    logic              frame_end;
    status_t           status;
    logic [PLEN_W-1:0] payload_length;
  } res_t;

endpackage

// File: hw/rtl/sxfd_in_if.sv
// byte input channel
interface sxfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// File: hw/rtl/sxfd_out_if.sv
// decoded result channel
interface sxfd_out_if;
  import sxfd_pkg::*;

  logic              valid;
  logic              ready;
  logic [7:0]        command;
  logic [7:0]        payload_byte;
  logic              is_payload;
  logic              frame_end;
  status_t           status;
  logic [PLEN_W-1:0] payload_length;

  modport source (
    output valid, output command, output payload_byte, output is_payload,
    output frame_end, output status, output payload_length, input ready
  );
  modport sink (
    input valid, input command, input payload_byte, input is_payload,
    input frame_end, input status, input payload_length, output ready
  );
endinterface

// File: hw/rtl/sync_length_xor_frame_decoder_top.sv
// sync/length/xor framed byte stream decoder, top level
// path: a word accepted from in_ch lands in the input register, and its result is
//   registered in the output register once out_ch is free, then shows on out_ch
// throughput: one word per cycle while out_ch does not stall, set by the single pass from input to result register
// words that only advance the header produce no result
// reset: synchronous active low rst_n; returns to hunting for the first sync byte
module sync_length_xor_frame_decoder_top #(
  parameter int unsigned MAX_PAYLOAD = sxfd_pkg::MAX_PAYLOAD_DEF
) (
  input logic        clk,
  input logic        rst_n,
  sxfd_in_if.sink    in_ch,
  sxfd_out_if.source out_ch
);
  import sxfd_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [2:0] {
    PH_HUNT, PH_SYNC2, PH_CMD, PH_LEN_LO, PH_LEN_HI, PH_RSVD, PH_DATA, PH_CHECK
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [7:0]       frame_command_r, frame_command_nxt;
  logic [LEN_W-1:0] frame_length_r, frame_length_nxt;
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]       running_xor_r, running_xor_nxt;

  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             out_valid_r;
  res_t             out_res_r, res_nxt;

  logic             advance;
  logic             emit;
  logic [CNT_W:0]   cnt_inc;
  logic [LEN_W-1:0] len_full;

  always_comb begin
    advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
    in_ch.ready = !s1_valid_r || advance;
  end

  always_comb begin
    phase_nxt         = phase_r;
    frame_command_nxt = frame_command_r;
    frame_length_nxt  = frame_length_r;
    byte_count_nxt    = byte_count_r;
    running_xor_nxt   = running_xor_r ^ s1_byte_r;
    emit              = 1'b0;
    res_nxt           = '0;
    cnt_inc           = {1'b0, byte_count_r} + {{CNT_W{1'b0}}, 1'b1};
    len_full          = {s1_byte_r, frame_length_r[7:0]};
    unique case (phase_r)
      PH_HUNT: begin
        if (s1_byte_r == SYNC_FIRST) begin
          running_xor_nxt = s1_byte_r;
          phase_nxt       = PH_SYNC2;
        end else begin
          emit              = 1'b1;
          res_nxt.frame_end = 1'b1;
          res_nxt.status    = ST_BAD_SYNC;
        end
      end
      PH_SYNC2: begin
        if (s1_byte_r == SYNC_SECOND) begin
          phase_nxt = PH_CMD;
        end else begin
          phase_nxt         = PH_HUNT;
          emit              = 1'b1;
          res_nxt.frame_end = 1'b1;
          res_nxt.status    = ST_BAD_SYNC;
        end
      end
      PH_CMD: begin
        frame_command_nxt = s1_byte_r;
        phase_nxt         = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frame_length_nxt = {{(LEN_W-8){1'b0}}, s1_byte_r};
        phase_nxt        = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        frame_length_nxt = len_full;
        if (len_full > LEN_W'(MAX_PAYLOAD)) begin
          phase_nxt         = PH_HUNT;
          emit              = 1'b1;
          res_nxt.command   = frame_command_r;
          res_nxt.frame_end = 1'b1;
          res_nxt.status    = ST_TOO_LONG;
        end else begin
          phase_nxt = PH_RSVD;
        end
      end
      PH_RSVD: begin
        byte_count_nxt = '0;
        phase_nxt      = (frame_length_r == '0) ? PH_CHECK : PH_DATA;
      end
      PH_DATA: begin
        byte_count_nxt = cnt_inc[CNT_W-1:0];
        if (LEN_W'(cnt_inc) >= frame_length_r) begin
          phase_nxt = PH_CHECK;
        end
        emit                 = 1'b1;
        res_nxt.command      = frame_command_r;
        res_nxt.payload_byte = s1_byte_r;
        res_nxt.is_payload   = 1'b1;
      end
      PH_CHECK: begin
        phase_nxt              = PH_HUNT;
        emit                   = 1'b1;
        res_nxt.command        = frame_command_r;
        res_nxt.frame_end      = 1'b1;
        res_nxt.status         = (s1_byte_r == running_xor_r) ? ST_OK : ST_BAD_CHECK;
        res_nxt.payload_length = frame_length_r[PLEN_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HUNT;
      frame_command_r <= '0;
      frame_length_r  <= '0;
      byte_count_r    <= '0;
      running_xor_r   <= '0;
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        s1_valid_r <= 1'b1;
        s1_byte_r  <= in_ch.data_byte;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        phase_r         <= phase_nxt;
        frame_command_r <= frame_command_nxt;
        frame_length_r  <= frame_length_nxt;
        byte_count_r    <= byte_count_nxt;
        running_xor_r   <= running_xor_nxt;
      end
      if (advance && emit) begin
        out_valid_r <= 1'b1;
        out_res_r   <= res_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    out_ch.valid          = out_valid_r;
    out_ch.command        = out_res_r.command;
    out_ch.payload_byte   = out_res_r.payload_byte;
    out_ch.is_payload     = out_res_r.is_payload;
    out_ch.frame_end      = out_res_r.frame_end;
    out_ch.status         = out_res_r.status;
    out_ch.payload_length = out_res_r.payload_length;
  end

  // a word is either payload or a frame close, never both
  a_pay_xor_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.is_payload && out_res_r.frame_end))
    else $error("payload and frame end set together");

  // status only carries meaning on a frame close
  a_status_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.frame_end) |-> (out_res_r.status == ST_OK))
    else $error("nonzero status without frame end");

  // payload phase only with a legal nonzero length
  a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |->
      (frame_length_r != '0 && frame_length_r <= LEN_W'(MAX_PAYLOAD)))
    else $error("payload phase with illegal length");

  // byte counter stays below the length during payload
  a_cnt_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (LEN_W'(byte_count_r) < frame_length_r))
    else $error("byte count ran past frame length");

endmodule
